// File: rtl/mdrc_pkg.sv
// Shared types, register indexes and digit correction functions for the rollover corrector.
`timescale 1ns / 1ps

package mdrc_pkg;

	typedef enum logic [1:0] {
		OP_ANALOG  = 2'd0,
		OP_DIGIT   = 2'd1,
		OP_CLASS11 = 2'd2,
		OP_NONE    = 2'd3
	} op_t;

	localparam logic [2:0] CFG_POINTER_TOL        = 3'd0;
	localparam logic [2:0] CFG_PREDECESSOR_AREA   = 3'd1;
	localparam logic [2:0] CFG_DIGIT_BAND         = 3'd2;
	localparam logic [2:0] CFG_FORWARD_AREA       = 3'd3;
	localparam logic [2:0] CFG_DIGIT_UNCERTAINTY  = 3'd4;
	localparam logic [2:0] CFG_SYNC_VALUE         = 3'd5;
	localparam logic [2:0] CFG_EXTENDED_RES       = 3'd6;

	localparam logic [6:0] VALUE_MAX   = 7'd99;
	localparam logic [6:0] CLASS11_MAX = 7'd9;

	typedef struct packed {
		logic [3:0] pointer_tol;
		logic [5:0] predecessor_area;
		logic [2:0] digit_band;
		logic [6:0] forward_area;
		logic [3:0] digit_uncertainty;
		logic [6:0] sync_value;
		logic       extended_resolution;
	} cfg_t;

	typedef struct packed {
		logic [3:0] digit;
		logic       unknown;
		logic       last;
	} res_t;

	// Integer part of a value below 128: multiply by 205 and drop eleven bits.
	function automatic logic [3:0] div10(input logic [6:0] v);
		logic [14:0] p;
		p = {8'd0, v} * 15'd205;
		return p[14:11];
	endfunction

	function automatic logic [3:0] mod10(input logic [6:0] v);
		logic [6:0] t;
		t = v - {div10(v), 3'd0} - {2'd0, div10(v), 1'b0};
		return t[3:0];
	endfunction

	function automatic logic [3:0] wrap_up(input logic [4:0] d);
		return (d >= 5'd10) ? 4'd0 : d[3:0];
	endfunction

	function automatic logic [3:0] wrap_down(input logic [3:0] d);
		return (d == 4'd0) ? 4'd9 : d - 4'd1;
	endfunction

	// Analog pointer: resolve ambiguity near a digit edge using the digit to the right.
	function automatic logic [3:0] eval_analog(input logic [6:0] v, input logic [3:0] pd,
			input logic [3:0] err);
		logic [7:0] hi;
		logic signed [8:0] lo;
		logic [6:0] hi_w;
		logic [6:0] lo_w;
		logic [3:0] hi_d;
		logic [3:0] lo_d;
		logic [3:0] res;
		hi = {1'b0, v} + {4'd0, err};
		hi_w = (hi >= 8'd100) ? 7'(hi - 8'd100) : hi[6:0];
		lo = $signed({2'b00, v}) - $signed({5'd0, err});
		lo_w = (lo < 0) ? 7'(lo + 9'sd100) : lo[6:0];
		hi_d = div10(hi_w);
		lo_d = div10(lo_w);
		res = div10(v);
		if (lo_d != hi_d) begin
			if (pd <= err) begin
				res = hi_d;
			end else if ($signed({1'b0, pd}) >= $signed(5'sd10 - $signed({1'b0, err}))) begin
				res = lo_d;
			end
		end
		return res;
	endfunction

	// Continuous digit that follows an analog pointer.
	function automatic logic [3:0] eval_transition(input logic [6:0] v, input logic [6:0] pv,
			input logic [3:0] pd, input cfg_t cfg);
		logic [3:0] ip;
		logic [3:0] dp;
		logic [3:0] r;
		logic near;
		ip = div10(v);
		dp = mod10(v);
		near = ($signed({1'b0, dp}) >= $signed(5'sd10 - $signed({1'b0, cfg.digit_uncertainty})))
			|| (pd <= 4'd4 && dp >= 4'd6);
		r = ip;
		if (near && dp >= 4'd5) begin
			r = wrap_up({1'b0, ip} + 5'd1);
			if (pd >= 4'd6 && (pv > cfg.sync_value || pv <= 7'd2)) begin
				r = wrap_down(r);
			end
		end
		return r;
	endfunction

	// Continuous digit that follows another digit: band rounding and zero crossing.
	function automatic logic [3:0] eval_digit(input logic [6:0] v, input logic [6:0] pv,
			input logic [3:0] pd, input cfg_t cfg);
		logic [3:0] ip;
		logic [3:0] dp;
		logic [3:0] up;
		logic [3:0] r;
		logic [6:0] pa;
		ip = div10(v);
		dp = mod10(v);
		up = wrap_up({1'b0, ip} + 5'd1);
		pa = {1'b0, cfg.predecessor_area};
		if (pv >= pa && pv <= 7'd100 - pa) begin
			r = ((dp <= {1'b0, cfg.digit_band} || dp >= 4'd10 - {1'b0, cfg.digit_band})
				&& dp >= 4'd5) ? up : ip;
		end else if (pd <= 4'd1) begin
			r = (dp >= 4'd5) ? up : ip;
		end else if ((pv <= cfg.forward_area && pd == div10(pv)) || dp >= 4'd4) begin
			r = ip;
		end else begin
			r = wrap_down(ip);
		end
		return r;
	endfunction

endpackage

// File: rtl/meter_digit_rollover_correction.sv
// Meter digit rollover corrector: input register, correction logic and a two-entry result queue.
//
//  channel | handshake            | payload
//  --------+----------------------+------------------------------------------
//  in      | in_valid / in_ready  | opcode, value, rejected, start_of_number
//  out     | out_valid / out_ready| digit, unknown, last
//  cfg     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// An accepted beat is registered in the input register, corrected from there and written
// into the result queue, whose head offers its first result.
// One beat per cycle is sustained while out_ready stays high and each yields one result;
// a beat that yields two results (first position with extended resolution) pushes both.
// The queue holds two results; the input register stalls while they do not fit.
// Reset restores the register defaults and clears the position history.
`timescale 1ns / 1ps

module meter_digit_rollover_correction import mdrc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] opcode,
	input  logic [6:0] value,
	input  logic       rejected,
	input  logic       start_of_number,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [3:0] digit,
	output logic       unknown,
	output logic       last,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [2:0] cfg_index,
	input  logic [6:0] cfg_data
);

	cfg_t cfg_q;

	logic       valid_s1;
	logic [1:0] opcode_s1;
	logic [6:0] value_s1;
	logic       rejected_s1;
	logic       start_s1;

	logic [6:0] prev_value_q;
	logic [3:0] prev_digit_q;
	logic       prev_valid_q;
	logic       prev_analog_q;

	res_t       res_q [2];
	logic [1:0] cnt_q;

	logic [6:0] v;
	logic [3:0] ip;
	logic [3:0] dp;
	logic       have;
	logic       ext_start;
	logic [3:0] r;
	res_t       r0;
	res_t       r1;
	logic [1:0] n_res;
	logic [6:0] nx_value;
	logic [3:0] nx_digit;
	logic       nx_valid;
	logic       nx_analog;

	logic       pop;
	logic       s1_move;
	logic [1:0] cnt_pop;
	logic [1:0] push_n;
	logic [2:0] room;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pointer_tol         <= 4'd3;
			cfg_q.predecessor_area    <= 6'd7;
			cfg_q.digit_band          <= 3'd3;
			cfg_q.forward_area        <= 7'd97;
			cfg_q.digit_uncertainty   <= 4'd2;
			cfg_q.sync_value          <= 7'd92;
			cfg_q.extended_resolution <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_POINTER_TOL:       cfg_q.pointer_tol         <= cfg_data[3:0];
				CFG_PREDECESSOR_AREA:  cfg_q.predecessor_area    <= cfg_data[5:0];
				CFG_DIGIT_BAND:        cfg_q.digit_band          <= cfg_data[2:0];
				CFG_FORWARD_AREA:      cfg_q.forward_area        <= cfg_data;
				CFG_DIGIT_UNCERTAINTY: cfg_q.digit_uncertainty   <= cfg_data[3:0];
				CFG_SYNC_VALUE:        cfg_q.sync_value          <= cfg_data;
				CFG_EXTENDED_RES:      cfg_q.extended_resolution <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	assign pop       = out_valid && out_ready;
	assign room      = 3'd2 - {1'b0, cnt_q} + {2'd0, pop};
	assign s1_move   = valid_s1 && ({1'b0, n_res} <= room);
	assign in_ready  = !valid_s1 || s1_move;
	assign cnt_pop   = cnt_q - {1'b0, pop};
	assign push_n    = s1_move ? n_res : 2'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready) begin
			opcode_s1   <= opcode;
			value_s1    <= value;
			rejected_s1 <= rejected;
			start_s1    <= start_of_number;
		end
	end

	// Correction of the registered position against the history of the previous one.
	always_comb begin
		v         = (value_s1 > VALUE_MAX) ? VALUE_MAX : value_s1;
		ip        = div10(v);
		dp        = mod10(v);
		have      = prev_valid_q && !start_s1;
		ext_start = start_s1 && cfg_q.extended_resolution;
		r         = ip;
		r0        = '0;
		r1        = '0;
		n_res     = 2'd0;
		nx_value  = prev_value_q;
		nx_digit  = prev_digit_q;
		nx_valid  = prev_valid_q && !start_s1;
		nx_analog = prev_analog_q && !start_s1;
		unique case (op_t'(opcode_s1))
			OP_ANALOG: begin
				r         = have ? eval_analog(v, prev_digit_q, cfg_q.pointer_tol) : ip;
				nx_value  = v;
				nx_digit  = r;
				nx_valid  = 1'b1;
				nx_analog = 1'b1;
				if (ext_start) begin
					r0    = '{digit: dp, unknown: 1'b0, last: 1'b0};
					r1    = '{digit: r, unknown: 1'b0, last: 1'b1};
					n_res = 2'd2;
				end else begin
					r0    = '{digit: r, unknown: 1'b0, last: 1'b1};
					n_res = 2'd1;
				end
			end
			OP_DIGIT: begin
				nx_value  = v;
				nx_analog = 1'b0;
				if (rejected_s1) begin
					nx_valid = 1'b0;
					if (ext_start) begin
						r0    = '{digit: 4'd0, unknown: 1'b1, last: 1'b0};
						r1    = '{digit: 4'd0, unknown: 1'b1, last: 1'b1};
						n_res = 2'd2;
					end else begin
						r0    = '{digit: 4'd0, unknown: 1'b1, last: 1'b1};
						n_res = 2'd1;
					end
				end else if (ext_start) begin
					r0       = '{digit: dp, unknown: 1'b0, last: 1'b0};
					r1       = '{digit: ip, unknown: 1'b0, last: 1'b1};
					n_res    = 2'd2;
					nx_digit = ip;
					nx_valid = 1'b1;
				end else begin
					if (!have) begin
						r = ip;
					end else if (prev_analog_q) begin
						r = eval_transition(v, prev_value_q, prev_digit_q, cfg_q);
					end else begin
						r = eval_digit(v, prev_value_q, prev_digit_q, cfg_q);
					end
					r0       = '{digit: r, unknown: 1'b0, last: 1'b1};
					n_res    = 2'd1;
					nx_digit = r;
					nx_valid = 1'b1;
				end
			end
			OP_CLASS11: begin
				nx_value  = value_s1;
				nx_analog = 1'b0;
				n_res     = 2'd1;
				if (value_s1 > CLASS11_MAX) begin
					r0       = '{digit: 4'd0, unknown: 1'b1, last: 1'b1};
					nx_valid = 1'b0;
				end else begin
					r0       = '{digit: value_s1[3:0], unknown: 1'b0, last: 1'b1};
					nx_digit = value_s1[3:0];
					nx_valid = 1'b1;
				end
			end
			OP_NONE: begin
				// No result and the history is left as it was.
				nx_valid  = prev_valid_q;
				nx_analog = prev_analog_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_value_q  <= '0;
			prev_digit_q  <= '0;
			prev_valid_q  <= 1'b0;
			prev_analog_q <= 1'b0;
		end else if (s1_move) begin
			prev_value_q  <= nx_value;
			prev_digit_q  <= nx_digit;
			prev_valid_q  <= nx_valid;
			prev_analog_q <= nx_analog;
		end
	end

	// Result queue: slot 0 is the head on the output ports.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			cnt_q <= cnt_pop + push_n;
		end
	end

	always_ff @(posedge clk) begin
		if (cnt_pop != 2'd0) begin
			res_q[0] <= pop ? res_q[1] : res_q[0];
		end else begin
			res_q[0] <= r0;
		end
		if (cnt_pop == 2'd2) begin
			res_q[1] <= res_q[1];
		end else if (cnt_pop == 2'd1) begin
			res_q[1] <= r0;
		end else begin
			res_q[1] <= r1;
		end
	end

	assign out_valid = (cnt_q != 2'd0);
	assign digit     = res_q[0].digit;
	assign unknown   = res_q[0].unknown;
	assign last      = res_q[0].last;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("result queue holds more than two beats");

	a_unknown_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && unknown |-> digit == 4'd0)
		else $error("unknown result carries a nonzero digit");

	a_digit_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> digit <= 4'd9)
		else $error("result digit above nine");

	a_pair_order: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == 2'd2 && !res_q[0].last |-> res_q[1].last)
		else $error("tenths beat not followed by its integer beat");

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> valid_s1 && cnt_q != 2'd0)
		else $error("input stalled while the result queue is empty");

endmodule
